### rtl/core/apip_pkg.sv
// ----------------------------------------------------------------------------
// apip_pkg
// Shared types and constants of the ascii radix integer parser.
// ----------------------------------------------------------------------------
package apip_pkg;

  localparam int unsigned ValueBitsDef  = 32;
  localparam int unsigned OffsetBitsDef = 16;
  localparam int unsigned RadixBits     = 6;

  localparam logic [RadixBits-1:0] RadixReset = 6'd10;
  localparam logic [RadixBits-1:0] BaseDec    = 6'd10;
  localparam logic [RadixBits-1:0] BaseOct    = 6'd8;
  localparam logic [RadixBits-1:0] BaseHex    = 6'd16;
  localparam logic [RadixBits-1:0] BaseAuto   = 6'd0;

  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowZ   = 8'h7a;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpZ    = 8'h5a;
  localparam logic [7:0] ChLowX   = 8'h78;
  localparam logic [7:0] ChUpX    = 8'h58;

  typedef enum logic [3:0] {
    PhIdle   = 4'b0001,
    PhSpaces = 4'b0010,
    PhPrefix = 4'b0100,
    PhDigits = 4'b1000
  } phase_e;

  typedef struct packed {
    phase_e                phase;
    logic [RadixBits-1:0]  base;
  } ctrl_t;

endpackage

### rtl/core/apip_step.sv
// ----------------------------------------------------------------------------
// apip_step
// Per-character parse step: space skipping, prefix handling, digit decode, multiply-add.
// ----------------------------------------------------------------------------
module apip_step import apip_pkg::*; #(
  parameter int unsigned ValueBits  = ValueBitsDef,
  parameter int unsigned OffsetBits = OffsetBitsDef
) (
  input  logic [7:0]            ch_i,
  input  logic                  first_i,
  input  logic [RadixBits-1:0]  radix_i,
  input  ctrl_t                 ctrl_i,
  input  logic [ValueBits-1:0]  acc_i,
  input  logic [OffsetBits-1:0] cnt_i,
  output ctrl_t                 ctrl_o,
  output logic [ValueBits-1:0]  acc_o,
  output logic [OffsetBits-1:0] cnt_o,
  output logic                  emit_o
);

  ctrl_t                 ctrl_s;
  logic [ValueBits-1:0]  acc_s;
  logic [OffsetBits-1:0] cnt_s;
  logic [OffsetBits-1:0] cnt_inc;
  logic [RadixBits-1:0]  digit;
  logic                  digit_ok;
  logic                  do_digit;

  // digit value 0..35, flag low for anything else
  always_comb begin
    digit    = '0;
    digit_ok = 1'b0;
    if (ch_i >= ChZero && ch_i <= ChNine) begin
      digit    = 6'(ch_i - ChZero);
      digit_ok = 1'b1;
    end else if (ch_i >= ChLowA && ch_i <= ChLowZ) begin
      digit    = 6'(ch_i - ChLowA) + 6'd10;
      digit_ok = 1'b1;
    end else if (ch_i >= ChUpA && ch_i <= ChUpZ) begin
      digit    = 6'(ch_i - ChUpA) + 6'd10;
      digit_ok = 1'b1;
    end
  end

  always_comb begin
    ctrl_s = ctrl_i;
    acc_s  = acc_i;
    cnt_s  = cnt_i;
    if (first_i) begin
      ctrl_s.phase = PhSpaces;
      ctrl_s.base  = radix_i;
      acc_s        = '0;
      cnt_s        = '0;
    end
    cnt_inc = (cnt_s == {OffsetBits{1'b1}}) ? cnt_s : cnt_s + 1'b1;

    ctrl_o   = ctrl_s;
    acc_o    = acc_s;
    cnt_o    = cnt_s;
    emit_o   = 1'b0;
    do_digit = 1'b0;

    unique case (ctrl_s.phase)
      PhIdle: begin
      end
      PhSpaces: begin
        if (ch_i == ChSpace) begin
          cnt_o = cnt_inc;
        end else if (ctrl_s.base == BaseAuto && ch_i == ChZero) begin
          cnt_o        = cnt_inc;
          ctrl_o.phase = PhPrefix;
        end else begin
          if (ctrl_s.base == BaseAuto) ctrl_o.base = BaseDec;
          do_digit = 1'b1;
        end
      end
      PhPrefix: begin
        if (ch_i == ChLowX || ch_i == ChUpX) begin
          ctrl_o.base  = BaseHex;
          ctrl_o.phase = PhDigits;
          cnt_o        = cnt_inc;
        end else begin
          ctrl_o.base = BaseOct;
          do_digit    = 1'b1;
        end
      end
      PhDigits: begin
        do_digit = 1'b1;
      end
      default: begin
        ctrl_o.phase = PhIdle;
      end
    endcase

    if (do_digit) begin
      if (digit_ok && digit < ctrl_o.base) begin
        ctrl_o.phase = PhDigits;
        acc_o        = acc_s * ValueBits'(ctrl_o.base) + ValueBits'(digit);
        cnt_o        = cnt_inc;
      end else begin
        ctrl_o.phase = PhIdle;
        emit_o       = 1'b1;
      end
    end
  end

endmodule

### rtl/core/ascii_radix_integer_parser.sv
// ----------------------------------------------------------------------------
// ascii_radix_integer_parser
// Streams characters in, emits the unsigned value and offset of each string.
// ----------------------------------------------------------------------------
//  channel  signals                                   direction
//  input    in_valid_i in_ready_o ch_i first_i        in
//  output   out_valid_o out_ready_i value_o end_offset_o   out
//  config   cfg_we_i cfg_wdata_i                      in
//
//  one character per cycle sustained while no result is held; a result is
//  registered when its terminator is parsed out of the input register
//  the per-character multiply-add in apip_step sets the longest combinational path
//  reset clears state to idle with radix ten
//  a held result stalls the parse stage; one more character is buffered
// ----------------------------------------------------------------------------
module ascii_radix_integer_parser import apip_pkg::*; #(
  parameter int unsigned ValueBits  = ValueBitsDef,
  parameter int unsigned OffsetBits = OffsetBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            ch_i,
  input  logic                  first_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ValueBits-1:0]  value_o,
  output logic [OffsetBits-1:0] end_offset_o,
  input  logic                  cfg_we_i,
  input  logic [RadixBits-1:0]  cfg_wdata_i
);

  logic                  in_valid_q;
  logic [7:0]            ch_q;
  logic                  first_q;
  logic [RadixBits-1:0]  radix_q;
  ctrl_t                 ctrl_q, ctrl_d;
  logic [ValueBits-1:0]  acc_q, acc_d;
  logic [OffsetBits-1:0] cnt_q, cnt_d;
  logic                  out_valid_q;
  logic [ValueBits-1:0]  value_q;
  logic [OffsetBits-1:0] offset_q;
  logic                  emit;
  logic                  fire;

  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  apip_step #(
    .ValueBits  (ValueBits),
    .OffsetBits (OffsetBits)
  ) u_step (
    .ch_i    (ch_q),
    .first_i (first_q),
    .radix_i (radix_q),
    .ctrl_i  (ctrl_q),
    .acc_i   (acc_q),
    .cnt_i   (cnt_q),
    .ctrl_o  (ctrl_d),
    .acc_o   (acc_d),
    .cnt_o   (cnt_d),
    .emit_o  (emit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      radix_q     <= RadixReset;
      ctrl_q      <= '{phase: PhIdle, base: BaseDec};
      acc_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) radix_q <= cfg_wdata_i;
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (fire) begin
        ctrl_q <= ctrl_d;
        acc_q  <= acc_d;
        cnt_q  <= cnt_d;
      end
      if (fire && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ch_q    <= ch_i;
      first_q <= first_i;
    end
    if (fire && emit) begin
      value_q  <= acc_d;
      offset_q <= cnt_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign end_offset_o = offset_q;

endmodule

### rtl/core/apip_checker.sv
// ----------------------------------------------------------------------------
// apip_checker
// Port-level checks on the parser's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module apip_checker import apip_pkg::*; #(
  parameter int unsigned ValueBits  = ValueBitsDef,
  parameter int unsigned OffsetBits = OffsetBitsDef
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [ValueBits-1:0]  value_o,
  input logic [OffsetBits-1:0] end_offset_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_o) && $stable(end_offset_o))
    else $error("result changed while stalled");

  // input backpressure only comes from a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output stall");

  // a transfer taken during an output stall fills the single buffer slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && in_valid_i && in_ready_o |=> in_ready_o == out_ready_i)
    else $error("input buffer depth mismatch");

  // no result right out of reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid after reset");

endmodule

bind ascii_radix_integer_parser apip_checker #(
  .ValueBits  (ValueBits),
  .OffsetBits (OffsetBits)
) u_apip_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .value_o      (value_o),
  .end_offset_o (end_offset_o)
);

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams character strings into the ascii radix integer parser under random
// input gaps and output stalls. An in-file parser model predicts each result,
// and every result transfer is compared field by field. Directed strings cover
// prefixes and wrap; random strings cover the radix settings.
// ----------------------------------------------------------------------------
module testbench import apip_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned DrainWait  = 8;
  localparam int unsigned TailWait   = 20;
  localparam int unsigned MaxPrinted = 30;
  localparam logic [7:0]  NotDigit   = 8'hff;
  localparam logic [7:0]  ChNul      = 8'h00;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
  } char_item_t;

  typedef struct packed {
    logic [ValueBitsDef-1:0]  value;
    logic [OffsetBitsDef-1:0] offset;
  } parse_result_t;

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     in_valid_i   = 1'b0;
  logic                     in_ready_o;
  logic [7:0]               ch_i         = '0;
  logic                     first_i      = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i  = 1'b0;
  logic [ValueBitsDef-1:0]  value_o;
  logic [OffsetBitsDef-1:0] end_offset_o;
  logic                     cfg_we_i     = 1'b0;
  logic [RadixBits-1:0]     cfg_wdata_i  = '0;

  ascii_radix_integer_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .ch_i        (ch_i),
    .first_i     (first_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .end_offset_o(end_offset_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  char_item_t    pending_chars[$];
  parse_result_t expected_results[$];

  // parser model state
  phase_e                   parse_phase = PhIdle;
  logic [ValueBitsDef-1:0]  parse_acc   = '0;
  logic [OffsetBitsDef-1:0] parse_count = '0;
  logic [RadixBits-1:0]     parse_base  = BaseDec;
  logic [RadixBits-1:0]     radix_copy  = RadixReset;

  int unsigned in_idle_pct  = 0;
  int unsigned out_idle_pct = 0;
  bit          calm         = 1'b0;
  bit          start_of_string;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned error_count  = 0;
  int unsigned chars_taken  = 0;
  int unsigned strings_seen = 0;
  int unsigned results_seen = 0;
  int unsigned radix_writes = 0;

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    if (error_count < MaxPrinted) begin
      $display("[%0t] mismatch %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    end
    error_count++;
  endtask

  function automatic logic [7:0] digit_value(logic [7:0] c);
    if (c >= ChZero && c <= ChNine) return c - ChZero;
    if (c >= ChLowA && c <= ChLowZ) return c - ChLowA + 8'd10;
    if (c >= ChUpA && c <= ChUpZ) return c - ChUpA + 8'd10;
    return NotDigit;
  endfunction

  function automatic void count_char();
    if (parse_count != '1) parse_count++;
  endfunction

  // returns 1 when this character ends the string
  function automatic bit predict_char(input logic [7:0] c, input logic first,
                                      output parse_result_t res);
    logic [7:0] d;
    res = '0;
    if (first) begin
      parse_acc   = '0;
      parse_count = '0;
      parse_base  = radix_copy;
      parse_phase = PhSpaces;
    end
    case (parse_phase)
      PhIdle: return 1'b0;
      PhSpaces: begin
        if (c == ChSpace) begin
          count_char();
          return 1'b0;
        end
        if (parse_base == BaseAuto) begin
          if (c == ChZero) begin
            count_char();
            parse_phase = PhPrefix;
            return 1'b0;
          end
          parse_base = BaseDec;
        end
        parse_phase = PhDigits;
      end
      PhPrefix: begin
        if (c == ChLowX || c == ChUpX) begin
          parse_base  = BaseHex;
          count_char();
          parse_phase = PhDigits;
          return 1'b0;
        end
        parse_base  = BaseOct;
        parse_phase = PhDigits;
      end
      default: ;
    endcase
    d = digit_value(c);
    if (d < {2'b00, parse_base}) begin
      parse_acc = parse_acc * parse_base + d;
      count_char();
      return 1'b0;
    end
    res.value   = parse_acc;
    res.offset  = parse_count;
    parse_phase = PhIdle;
    return 1'b1;
  endfunction

  // input side: one transfer per handshake, gaps only between transfers
  always @(posedge clk_i or negedge rst_ni) begin : drive_chars
    char_item_t nxt;
    logic       valid_n;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      ch_i       <= '0;
      first_i    <= 1'b0;
      gap_left   = 0;
    end else if (!in_valid_i || in_ready_o) begin
      valid_n = 1'b0;
      nxt     = '{ch: ch_i, first: first_i};
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_chars.size() > 0) begin
        if (!calm && $urandom_range(99) < in_idle_pct) begin
          gap_left = $urandom_range(1, 10) - 1;
        end else begin
          nxt     = pending_chars.pop_front();
          valid_n = 1'b1;
        end
      end
      in_valid_i <= valid_n;
      ch_i       <= nxt.ch;
      first_i    <= nxt.first;
    end
  end

  // observes both channels and the register port, checks results, drives ready
  always @(posedge clk_i) begin : watch_results
    parse_result_t res;
    parse_result_t want;
    bit            moved;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      moved = 1'b0;
      if (cfg_we_i) radix_copy = cfg_wdata_i;
      if (in_valid_i && in_ready_o) begin
        moved = 1'b1;
        chars_taken++;
        if (first_i) strings_seen++;
        if (predict_char(ch_i, first_i, res)) expected_results.push_back(res);
      end
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result value", 0, value_o);
        end else begin
          want = expected_results.pop_front();
          if (value_o !== want.value) report_mismatch("value", want.value, value_o);
          if (end_offset_o !== want.offset) begin
            report_mismatch("end_offset", want.offset, end_offset_o);
          end
        end
      end

      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(99) < out_idle_pct) begin
        stall_left = $urandom_range(1, 10) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end

      if (moved || (pending_chars.size() == 0 && !in_valid_i && expected_results.size() == 0)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
          $display("[%0t] timeout: no transfer for %0d cycles", $realtime, StallLimit);
          $display("ascii_radix_integer_parser verification failed");
          $finish;
        end
      end
    end
  end

  task automatic push_char(logic [7:0] c);
    pending_chars.push_back('{ch: c, first: start_of_string});
    start_of_string = 1'b0;
  endtask

  task automatic push_str(string s, logic [7:0] term);
    start_of_string = 1'b1;
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
    push_char(term);
  endtask

  function automatic logic [7:0] rand_digit(logic [RadixBits-1:0] base, bit nonzero);
    int unsigned top;
    int unsigned v;
    top = (base > 36) ? 35 : base - 1;
    v   = $urandom_range((nonzero && top >= 1) ? 1 : 0, top);
    if (v < 10) return ChZero + 8'(v);
    return ($urandom_range(1) ? ChLowA : ChUpA) + 8'(v - 10);
  endfunction

  // one random string; returns how many characters it queued
  task automatic gen_string(input logic [RadixBits-1:0] radix, output int unsigned made);
    int unsigned n;
    int unsigned pre;
    logic [RadixBits-1:0] base;
    made = 0;
    if ($urandom_range(9) < 2) begin
      // noise and broken strings, including restarts mid-string
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        pending_chars.push_back('{ch: 8'($urandom_range(255)),
                                  first: (i == 0) || ($urandom_range(7) == 0)});
      end
      made = n;
      return;
    end
    start_of_string = 1'b1;
    n = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0;
    for (int i = 0; i < n; i++) push_char(ChSpace);
    made += n;
    base = radix;
    pre  = 0;
    if (radix == BaseAuto) begin
      pre = $urandom_range(2);
      base = BaseDec;
      if (pre >= 1) begin
        push_char(ChZero);
        base = BaseOct;
        made++;
      end
      if (pre == 2) begin
        push_char($urandom_range(1) ? ChLowX : ChUpX);
        base = BaseHex;
        made++;
      end
    end
    n = $urandom_range(0, 12);
    for (int i = 0; i < n; i++) begin
      push_char(rand_digit(base, radix == BaseAuto && pre == 0 && i == 0));
    end
    push_char($urandom_range(1) ? ChNul : 8'($urandom_range(255)));
    made += n + 1;
    // trailing characters after the end are ignored by the parser
    n = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      pending_chars.push_back('{ch: 8'($urandom_range(255)), first: 1'b0});
    end
    made += n;
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (pending_chars.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_radix(logic [RadixBits-1:0] r);
    drain();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    radix_writes++;
    @(negedge clk_i);
  endtask

  task automatic random_strings(logic [RadixBits-1:0] radix, int unsigned budget);
    int unsigned made;
    int unsigned total;
    total = 0;
    while (total < budget) begin
      gen_string(radix, made);
      total += made;
    end
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset radix is ten; characters before any first flag are ignored
    in_idle_pct  = 20;
    out_idle_pct = 20;
    pending_chars.push_back('{ch: ChUpA, first: 1'b0});
    pending_chars.push_back('{ch: 8'hff, first: 1'b0});
    push_str(" 42", ChNul);
    push_str("", ChNul);
    push_str("4294967295", ChNul);
    // restart mid-string abandons the first one
    start_of_string = 1'b1;
    push_char("9");
    push_char("8");
    push_str("7", ChLowX);
    random_strings(RadixReset, 60);

    write_radix(BaseAuto);
    in_idle_pct  = 30;
    out_idle_pct = 10;
    push_str("0X", ChNul);
    push_str(" 017", ChSpace);
    push_str("0xFFFFFFFFF", ChNul);
    push_str("0", "9");
    random_strings(BaseAuto, 90);

    write_radix(BaseHex);
    in_idle_pct  = 10;
    out_idle_pct = 40;
    push_str("fFfFfFfF", ChNul);
    random_strings(BaseHex, 90);

    write_radix(6'd36);
    in_idle_pct  = 50;
    out_idle_pct = 50;
    push_str("zZ9", ChNul);
    random_strings(6'd36, 80);

    write_radix(6'd1);
    in_idle_pct  = 15;
    out_idle_pct = 15;
    push_str("000", "1");
    random_strings(6'd1, 50);

    write_radix(6'd63);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    push_str("Zz", "{");
    random_strings(6'd63, 80);

    write_radix(6'd2);
    in_idle_pct  = 40;
    out_idle_pct = 5;
    random_strings(6'd2, 80);

    write_radix(BaseOct);
    in_idle_pct  = 20;
    out_idle_pct = 30;
    random_strings(BaseOct, 80);

    // final stretch in decimal with no idling on either side
    write_radix(BaseDec);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    calm = 1'b1;
    random_strings(BaseDec, 100);
    drain();
    repeat (TailWait) @(posedge clk_i);

    if (expected_results.size() != 0) begin
      report_mismatch("results never delivered", 0, expected_results.size());
    end
    $display("run covered %0d characters in %0d strings over %0d radix writes",
             chars_taken, strings_seen, radix_writes);
    $display("%0d results checked, %0d mismatches", results_seen, error_count);
    if (error_count == 0) begin
      $display("ascii_radix_integer_parser verification clean");
    end else begin
      $display("ascii_radix_integer_parser verification failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/apip_pkg.sv
rtl/core/apip_step.sv
rtl/core/ascii_radix_integer_parser.sv
rtl/core/apip_checker.sv
tb/sv/testbench.sv
